@@ design/lfu_pkg.sv @@
// Shared types and constants for the LFU key cache.
// Used by lfu_cell, lfu_ctrl and the top level lfu_key_cache.
package lfu_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned KEY_CHARS = 5;
  localparam int unsigned KEY_W     = KEY_CHARS * 8;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned IDX_W     = $clog2(ENTRIES);
  localparam int unsigned NV_W      = $clog2(ENTRIES + 1);
  localparam int unsigned DATA_W    = ((KEY_W + COUNT_W + 7) / 8) * 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    KIND_PRELOAD = 2'd0,
    KIND_ACCESS  = 2'd1,
    KIND_DUMP    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    STAT_HIT      = 3'd0,
    STAT_FILL     = 3'd1,
    STAT_EVICT    = 3'd2,
    STAT_LOAD_OK  = 3'd3,
    STAT_LOAD_REJ = 3'd4,
    STAT_DUMP     = 3'd5
  } status_e;

  // Values broadcast from the controller to every cell.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] thr_count;
    logic [KEY_W-1:0]   thr_key;
    logic               use_thr;
  } probe_t;

  // Scan result handed from cell to cell.
  typedef struct packed {
    logic               match;
    logic [IDX_W-1:0]   match_idx;
    logic [COUNT_W-1:0] match_count;
    logic               free;
    logic [IDX_W-1:0]   free_idx;
    logic               best_valid;
    logic [IDX_W-1:0]   best_idx;
    logic [COUNT_W-1:0] best_count;
    logic [KEY_W-1:0]   best_key;
    logic [NV_W-1:0]    n_valid;
  } token_t;

  // Slot write, broadcast to all cells and taken by the addressed one.
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] count;
  } wr_t;

endpackage

@@ design/lfu_cell.sv @@
// One slot of the LFU key cache: holds a key, its count and a valid bit,
// and folds its entry into the scan token passed on to the next cell.
// Depends on lfu_pkg.
module lfu_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [lfu_pkg::IDX_W-1:0]       idx_i,
  input  lfu_pkg::probe_t                 probe_i,
  input  lfu_pkg::wr_t                    wr_i,
  input  lfu_pkg::token_t                 tok_i,
  output lfu_pkg::token_t                 tok_o
);

  logic                          valid_q;
  logic [lfu_pkg::KEY_W-1:0]     key_q;
  logic [lfu_pkg::COUNT_W-1:0]   count_q;
  lfu_pkg::token_t               tok_d, tok_q;
  logic                          above_thr;
  logic                          wr_hit;

  assign wr_hit = wr_i.en && (wr_i.idx == idx_i);

  always_comb begin
    tok_d     = tok_i;
    above_thr = !probe_i.use_thr ||
                ({count_q, key_q} > {probe_i.thr_count, probe_i.thr_key});
    if (valid_q && !tok_i.match && (key_q == probe_i.key)) begin
      tok_d.match       = 1'b1;
      tok_d.match_idx   = idx_i;
      tok_d.match_count = count_q;
    end
    // Earlier cells set the flag first, so the lowest free slot wins.
    if (!valid_q && !tok_i.free) begin
      tok_d.free     = 1'b1;
      tok_d.free_idx = idx_i;
    end
    if (valid_q && above_thr && (!tok_i.best_valid ||
        ({count_q, key_q} < {tok_i.best_count, tok_i.best_key}))) begin
      tok_d.best_valid = 1'b1;
      tok_d.best_idx   = idx_i;
      tok_d.best_count = count_q;
      tok_d.best_key   = key_q;
    end
    tok_d.n_valid = tok_i.n_valid + lfu_pkg::NV_W'(valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_hit) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      key_q   <= wr_i.key;
      count_q <= wr_i.count;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ design/lfu_ctrl.sv @@
// Sequencer of the LFU key cache: takes input transfers, runs scans along
// the cell chain, writes slots and holds the output register.
// Depends on lfu_pkg.
module lfu_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [lfu_pkg::DATA_W-1:0]    s_axis_tdata_i,
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [lfu_pkg::DATA_W-1:0]    m_axis_tdata_o,
  output logic [3:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o,
  output lfu_pkg::probe_t               probe_o,
  output lfu_pkg::wr_t                  wr_o,
  input  lfu_pkg::token_t               tok_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e                       state_q, state_d;
  logic [lfu_pkg::NV_W-1:0]     cnt_q, cnt_d;
  logic [lfu_pkg::NV_W-1:0]     left_q, left_d, left_now;
  logic                         first_q, first_d;
  lfu_pkg::kind_e               kind_q, kind_d, in_kind;
  logic [lfu_pkg::KEY_W-1:0]    key_q, key_d;
  logic [lfu_pkg::COUNT_W-1:0]  lcount_q, lcount_d;
  logic [lfu_pkg::COUNT_W-1:0]  thr_count_q, thr_count_d;
  logic [lfu_pkg::KEY_W-1:0]    thr_key_q, thr_key_d;

  logic                         out_valid_q, out_valid_d;
  lfu_pkg::status_e             out_status_q, out_status_d;
  logic [lfu_pkg::KEY_W-1:0]    out_key_q, out_key_d;
  logic [lfu_pkg::COUNT_W-1:0]  out_count_q, out_count_d;
  logic                         out_ev_q, out_ev_d;
  logic                         out_last_q, out_last_d;

  logic                         scan_done, out_free, act, in_fire;
  logic [lfu_pkg::COUNT_W-1:0]  inc_count;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_kind   = lfu_pkg::kind_e'(s_axis_tuser_i);
  assign scan_done = (state_q == ST_SCAN) && (cnt_q == lfu_pkg::NV_W'(lfu_pkg::ENTRIES));
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign act       = scan_done && out_free;
  assign left_now  = first_q ? tok_i.n_valid : left_q;
  assign inc_count = (tok_i.match_count == lfu_pkg::COUNT_MAX) ?
                     lfu_pkg::COUNT_MAX : tok_i.match_count + 1'b1;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    left_d       = left_q;
    first_d      = first_q;
    kind_d       = kind_q;
    key_d        = key_q;
    lcount_d     = lcount_q;
    thr_count_d  = thr_count_q;
    thr_key_d    = thr_key_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_count_d  = out_count_q;
    out_ev_d     = out_ev_q;
    out_last_d   = out_last_q;
    wr_o         = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_kind != lfu_pkg::KIND_NONE)) begin
          kind_d   = in_kind;
          key_d    = s_axis_tdata_i[lfu_pkg::KEY_W-1:0];
          lcount_d = s_axis_tdata_i[lfu_pkg::KEY_W +: lfu_pkg::COUNT_W];
          first_d  = 1'b1;
          cnt_d    = '0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_done) begin
          cnt_d = cnt_q + 1'b1;
        end else if (act) begin
          out_valid_d = 1'b1;
          out_key_d   = '0;
          out_count_d = '0;
          out_ev_d    = 1'b0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
          wr_o.key    = key_q;
          case (kind_q)
            lfu_pkg::KIND_PRELOAD: begin
              if (tok_i.match || !tok_i.free) begin
                out_status_d = lfu_pkg::STAT_LOAD_REJ;
              end else begin
                out_status_d = lfu_pkg::STAT_LOAD_OK;
                wr_o.en      = 1'b1;
                wr_o.idx     = tok_i.free_idx;
                wr_o.count   = lcount_q;
              end
            end
            lfu_pkg::KIND_ACCESS: begin
              wr_o.en = 1'b1;
              if (tok_i.match) begin
                out_status_d = lfu_pkg::STAT_HIT;
                out_count_d  = inc_count;
                wr_o.idx     = tok_i.match_idx;
                wr_o.count   = inc_count;
              end else if (tok_i.free) begin
                out_status_d = lfu_pkg::STAT_FILL;
                wr_o.idx     = tok_i.free_idx;
                wr_o.count   = lfu_pkg::COUNT_W'(1);
              end else begin
                out_status_d = lfu_pkg::STAT_EVICT;
                out_key_d    = tok_i.best_key;
                out_count_d  = tok_i.best_count;
                out_ev_d     = 1'b1;
                wr_o.idx     = tok_i.best_idx;
                wr_o.count   = lfu_pkg::COUNT_W'(1);
              end
            end
            lfu_pkg::KIND_DUMP: begin
              out_status_d = lfu_pkg::STAT_DUMP;
              // An empty table gives a single result that carries no entry.
              if (left_now != '0) begin
                out_key_d   = tok_i.best_key;
                out_count_d = tok_i.best_count;
                out_ev_d    = 1'b1;
                out_last_d  = (left_now == lfu_pkg::NV_W'(1));
                if (left_now != lfu_pkg::NV_W'(1)) begin
                  // Next pass looks for the smallest entry above this one.
                  left_d      = left_now - 1'b1;
                  thr_count_d = tok_i.best_count;
                  thr_key_d   = tok_i.best_key;
                  first_d     = 1'b0;
                  cnt_d       = '0;
                  state_d     = ST_SCAN;
                end
              end
            end
            default: begin
              out_valid_d = out_valid_q && !m_axis_tready_i;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      left_q      <= '0;
      first_q     <= 1'b1;
      kind_q      <= lfu_pkg::KIND_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      left_q      <= left_d;
      first_q     <= first_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    lcount_q     <= lcount_d;
    thr_count_q  <= thr_count_d;
    thr_key_q    <= thr_key_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_count_q  <= out_count_d;
    out_ev_q     <= out_ev_d;
    out_last_q   <= out_last_d;
  end

  assign probe_o.key       = key_q;
  assign probe_o.thr_count = thr_count_q;
  assign probe_o.thr_key   = thr_key_q;
  assign probe_o.use_thr   = !first_q;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = lfu_pkg::DATA_W'({out_count_q, out_key_q});
  assign m_axis_tuser_o  = {out_ev_q, out_status_q};
  assign m_axis_tlast_o  = out_last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= lfu_pkg::NV_W'(lfu_pkg::ENTRIES)))
    else $error("scan counter ran past the end of the chain");

  a_wr_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_o.en |=> (state_q == ST_IDLE))
    else $error("slot written without ending the item");

  a_dump_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && !first_q) |-> (left_q != '0))
    else $error("dump pass started with no entries left");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !act)
    else $error("result produced while output register is full");

endmodule

@@ design/lfu_key_cache.sv @@
// Top level of the LFU key cache: a chain of slot cells and a sequencer.
// Depends on lfu_pkg, lfu_cell and lfu_ctrl.
//
// Input channel s_axis: tuser carries the kind (preload, access, dump),
// tdata the key and the preload count. Output channel m_axis: tdata carries
// key and count, tuser the status and the entry flag, tlast the final result
// of an item.
// Each item starts a scan in which a token walks the chain of cells, one
// cell per cycle, gathering the key match, the first free slot and the
// smallest entry. A preload or access gives one result at the end of its
// scan, and the next item is taken once the sequencer is back in idle.
// A dump runs one scan per valid entry (one scan for an empty table) and
// emits one result per scan.
// A new item is taken only while no scan is running; an item of the unused
// kind is taken and dropped. When the receiver stalls, the result waits in
// the output register and the sequencer holds at the end of its scan.
// Reset clears all valid bits, so the table starts empty.
module lfu_key_cache (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [39:0] key, [55:40] entry_count
  input  logic [lfu_pkg::DATA_W-1:0]    s_axis_tdata_i,
  // [1:0] kind
  input  logic [1:0]                    s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [39:0] out_key, [55:40] out_count
  output logic [lfu_pkg::DATA_W-1:0]    m_axis_tdata_o,
  // [2:0] status, [3] entry_valid
  output logic [3:0]                    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  lfu_pkg::probe_t  probe;
  lfu_pkg::wr_t     wr;
  lfu_pkg::token_t  tok [lfu_pkg::ENTRIES+1];

  assign tok[0] = '0;

  for (genvar i = 0; i < lfu_pkg::ENTRIES; i++) begin : g_cell
    lfu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (lfu_pkg::IDX_W'(i)),
      .probe_i (probe),
      .wr_i    (wr),
      .tok_i   (tok[i]),
      .tok_o   (tok[i+1])
    );
  end

  lfu_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .probe_o         (probe),
    .wr_o            (wr),
    .tok_i           (tok[lfu_pkg::ENTRIES])
  );

endmodule
